// ===== rtl/core/stb_pkg.sv =====
// Shared types and constants for the software timer bank.
package stb_pkg;

  localparam int SLOTS        = 16;
  localparam int SLOT_W       = 4;
  localparam int TICK_DIVISOR = 5;
  localparam int RELOAD_W     = 30;
  localparam int COUNT_W      = 32;

  // Reciprocal for divide-by-constant: q = (t * DIV_M) >> (COUNT_W + DIV_SH)
  localparam int DIV_SH = $clog2(TICK_DIVISOR);
  localparam longint unsigned DIV_M_FULL =
    ((64'd1 << (COUNT_W + DIV_SH)) + 64'(TICK_DIVISOR) - 64'd1) / 64'(TICK_DIVISOR);
  localparam logic [COUNT_W:0] DIV_M = DIV_M_FULL[COUNT_W:0];

  localparam logic [RELOAD_W-1:0] RELOAD_MAX = '1;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_QUERY = 3'd3,
    OP_OPEN  = 3'd4,
    OP_CLOSE = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ARM,
    ST_SCAN,
    ST_FLUSH,
    ST_RESP
  } st_t;

  typedef struct packed {
    logic                periodic;
    logic                handler;
    logic [RELOAD_W-1:0] reload;
    logic [COUNT_W-1:0]  expiry;
  } slot_ent_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_ent_t         data;
  } ram_wr_t;

endpackage

// ===== rtl/core/software_timer_bank.sv =====
// Software timer bank: command sequencer, tick scan over the slot table, result register.
// Sequence: stop, query, open and close go from acceptance straight to the respond state;
//   start goes through clamp, reciprocal multiply, arm and respond, in that order.
// Throughput: one item at a time; a tick scans slots 1..SLOTS-1 one per cycle through
//   the single read port of the slot memory, except while a held event waits on a blocked output.
// Reset: rst clears the counter, the enable flag and the slot valid bits; the slot memory
//   itself is not cleared, an entry whose valid bit is low is never used.
module software_timer_bank (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot[3:0], timeout_units[35:4], periodic[36],
                                 // has_handler[37], zero pad [39:38]
  input  logic [2:0]  s_tuser,   // op
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // slot_out[3:0], active[4], zero pad [7:5]
  output logic [0:0]  m_tuser,   // kind: 0 expiry event, 1 command completion
  output logic        m_tlast    // final result of the input item
);

  localparam int SW = stb_pkg::SLOT_W;
  localparam int CW = stb_pkg::COUNT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(stb_pkg::SLOTS - 1);

  // input field unpacking
  logic [SW-1:0] in_slot;
  logic [CW-1:0] in_tmo;
  logic          in_per;
  logic          in_hdl;
  logic          in_range;

  assign in_slot  = s_tdata[3:0];
  assign in_tmo   = s_tdata[35:4];
  assign in_per   = s_tdata[36];
  assign in_hdl   = s_tdata[37];
  assign in_range = {1'b0, in_slot} < (SW + 1)'(stb_pkg::SLOTS);

  // control state
  stb_pkg::st_t            state, state_next;
  logic [CW-1:0]           count;
  logic                    enabled;
  logic [stb_pkg::SLOTS-1:0] vld;   // per-slot armed flag, cleared at once by reset/open/close
  logic [SW-1:0]           chk;     // slot under check during a scan

  // command context
  logic [SW-1:0]           cmd_slot;
  logic                    cmd_per;
  logic                    cmd_hdl;
  logic                    cmd_range;
  logic [SW-1:0]           resp_slot;
  logic                    resp_act;

  // held event: sent once the next one (or the scan end) tells whether it is last
  logic                    pend_v;
  logic [SW-1:0]           pend_slot;
  logic                    pend_act;

  // output register
  logic                    out_v;
  logic                    out_kind;
  logic [SW-1:0]           out_slot;
  logic                    out_act;
  logic                    out_last;

  // memory and divider
  stb_pkg::ram_wr_t        ram_wr;
  logic [SW-1:0]           rd_addr;
  stb_pkg::slot_ent_t      rd_data;
  logic [stb_pkg::RELOAD_W-1:0] reload;

  logic acc;
  logic out_free;
  logic hit, keep, stall;

  assign s_tready = (state == stb_pkg::ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !out_v || m_tready;

  // scan decisions for the slot whose entry is on the read port
  assign hit   = (state == stb_pkg::ST_SCAN) && vld[chk] && (rd_data.expiry == count);
  assign keep  = rd_data.periodic && rd_data.handler;
  assign stall = hit && pend_v && !out_free;

  stb_slot_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stb_reload_calc u_reload (
    .clk           (clk),
    .load          (acc),
    .timeout_units (in_tmo),
    .reload        (reload)
  );

  // next state, memory port control
  always_comb begin
    state_next      = state;
    rd_addr         = chk + SW'(1);
    ram_wr.en       = 1'b0;
    ram_wr.addr     = chk;
    ram_wr.data     = rd_data;
    case (state)
      stb_pkg::ST_IDLE: begin
        rd_addr = SW'(1);
        if (acc) begin
          case (s_tuser)
            stb_pkg::OP_TICK:  if (enabled) state_next = stb_pkg::ST_SCAN;
            stb_pkg::OP_START: state_next = stb_pkg::ST_DIV;
            stb_pkg::OP_STOP,
            stb_pkg::OP_QUERY,
            stb_pkg::OP_OPEN,
            stb_pkg::OP_CLOSE: state_next = stb_pkg::ST_RESP;
            default:           state_next = stb_pkg::ST_IDLE;
          endcase
        end
      end
      stb_pkg::ST_DIV: begin
        state_next = stb_pkg::ST_ARM;
      end
      stb_pkg::ST_ARM: begin
        ram_wr.en            = cmd_range;
        ram_wr.addr          = cmd_slot;
        ram_wr.data.periodic = cmd_per;
        ram_wr.data.handler  = cmd_hdl;
        ram_wr.data.reload   = reload;
        ram_wr.data.expiry   = count + CW'(reload);
        state_next           = stb_pkg::ST_RESP;
      end
      stb_pkg::ST_SCAN: begin
        if (stall) begin
          rd_addr = chk;   // re-read the same entry while held
        end
        // periodic re-arm writes back only the expiry
        ram_wr.en          = hit && !stall && keep;
        ram_wr.data.expiry = count + CW'(rd_data.reload);
        if (!stall && chk == LAST_SLOT) begin
          state_next = stb_pkg::ST_FLUSH;
        end
      end
      stb_pkg::ST_FLUSH: begin
        if (!pend_v || out_free) begin
          state_next = stb_pkg::ST_IDLE;
        end
      end
      stb_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = stb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counter, enable, valid bits, scan index, held event
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      enabled <= 1'b0;
      vld     <= '0;
      chk     <= '0;
      pend_v  <= 1'b0;
    end else begin
      case (state)
        stb_pkg::ST_IDLE: begin
          chk <= SW'(1);
          if (acc) begin
            case (s_tuser)
              stb_pkg::OP_TICK: begin
                if (enabled) count <= count + CW'(1);
              end
              stb_pkg::OP_STOP: begin
                if (in_range) vld[in_slot] <= 1'b0;
              end
              stb_pkg::OP_OPEN: begin
                vld     <= '0;
                enabled <= 1'b1;
                count   <= '0;
              end
              stb_pkg::OP_CLOSE: begin
                vld     <= '0;
                enabled <= 1'b0;
                count   <= '0;
              end
              default: ;
            endcase
          end
        end
        stb_pkg::ST_ARM: begin
          if (cmd_range) vld[cmd_slot] <= 1'b1;
        end
        stb_pkg::ST_SCAN: begin
          if (!stall) begin
            chk <= chk + SW'(1);
            if (hit) begin
              pend_v <= 1'b1;
              if (!keep) vld[chk] <= 1'b0;
            end
          end
        end
        stb_pkg::ST_FLUSH: begin
          if (out_free) pend_v <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_slot  <= in_slot;
      cmd_per   <= in_per;
      cmd_hdl   <= in_hdl;
      cmd_range <= in_range;
      case (s_tuser)
        stb_pkg::OP_STOP: begin
          resp_slot <= in_slot;
          resp_act  <= 1'b0;
        end
        stb_pkg::OP_QUERY: begin
          resp_slot <= in_slot;
          resp_act  <= in_range && vld[in_slot];
        end
        default: begin
          resp_slot <= '0;
          resp_act  <= 1'b0;
        end
      endcase
    end
    if (state == stb_pkg::ST_ARM) begin
      resp_slot <= cmd_slot;
      resp_act  <= cmd_range;
    end
    if (hit && !stall) begin
      pend_slot <= chk;
      pend_act  <= keep;
    end
  end

  // result register: loads a command completion, a superseded held event
  // (not last) or the final held event at scan end (last)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == stb_pkg::ST_RESP && out_free) begin
      out_v <= 1'b1;
    end else if (hit && pend_v && !stall) begin
      out_v <= 1'b1;
    end else if (state == stb_pkg::ST_FLUSH && pend_v && out_free) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == stb_pkg::ST_RESP && out_free) begin
      out_kind <= 1'b1;
      out_slot <= resp_slot;
      out_act  <= resp_act;
      out_last <= 1'b1;
    end else if (hit && pend_v && !stall) begin
      out_kind <= 1'b0;
      out_slot <= pend_slot;
      out_act  <= pend_act;
      out_last <= 1'b0;
    end else if (state == stb_pkg::ST_FLUSH && pend_v && out_free) begin
      out_kind <= 1'b0;
      out_slot <= pend_slot;
      out_act  <= pend_act;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid   = out_v;
  assign m_tdata    = {3'b000, out_act, out_slot};
  assign m_tuser[0] = out_kind;
  assign m_tlast    = out_last;

  // slot zero is never scanned
  a_scan_skips_zero: assert property (@(posedge clk) disable iff (rst)
    (state == stb_pkg::ST_SCAN) |-> (chk != '0))
    else $error("scan reached slot zero");

  // a held event exists only while a tick is being worked
  a_pend_in_tick: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (state == stb_pkg::ST_SCAN || state == stb_pkg::ST_FLUSH))
    else $error("held event outside a tick");

  // open leaves the bank enabled with a cleared counter and table
  a_open_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser == stb_pkg::OP_OPEN) |=> (enabled && count == '0 && vld == '0))
    else $error("open did not clear the bank");

  // a tick while disabled changes nothing and starts no scan
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser == stb_pkg::OP_TICK && !enabled) |=>
      ($stable(count) && state == stb_pkg::ST_IDLE))
    else $error("disabled tick had an effect");

  // the held event is never dropped while the output is blocked
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> (pend_v && $stable(pend_slot) && $stable(chk)))
    else $error("held event lost under back-pressure");

endmodule

// ===== rtl/core/stb_slot_ram.sv =====
// Slot table memory: one write port, one registered read port.
module stb_slot_ram (
  input  logic                        clk,
  input  stb_pkg::ram_wr_t            wr,
  input  logic [stb_pkg::SLOT_W-1:0]  rd_addr,
  output stb_pkg::slot_ent_t          rd_data
);

  stb_pkg::slot_ent_t mem [stb_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/stb_reload_calc.sv =====
// Reload computation: clamp, divide by the tick divisor via reciprocal, saturate.
module stb_reload_calc (
  input  logic                          clk,
  input  logic                          load,
  input  logic [stb_pkg::COUNT_W-1:0]   timeout_units,
  output logic [stb_pkg::RELOAD_W-1:0]  reload
);

  localparam int PROD_W = 2 * stb_pkg::COUNT_W + 1;

  logic [stb_pkg::COUNT_W-1:0] t_clamped;
  logic [PROD_W-1:0]           prod;
  logic [stb_pkg::COUNT_W-1:0] quot;

  // stage 1: clamp to at least one divisor
  always_ff @(posedge clk) begin
    if (load) begin
      if (timeout_units < stb_pkg::COUNT_W'(stb_pkg::TICK_DIVISOR)) begin
        t_clamped <= stb_pkg::COUNT_W'(stb_pkg::TICK_DIVISOR);
      end else begin
        t_clamped <= timeout_units;
      end
    end
  end

  // stage 2: multiply by reciprocal
  always_ff @(posedge clk) begin
    prod <= PROD_W'(t_clamped) * PROD_W'(stb_pkg::DIV_M);
  end

  assign quot = stb_pkg::COUNT_W'(prod >> (stb_pkg::COUNT_W + stb_pkg::DIV_SH));

  always_comb begin
    if (quot > stb_pkg::COUNT_W'(stb_pkg::RELOAD_MAX)) begin
      reload = stb_pkg::RELOAD_MAX;
    end else begin
      reload = quot[stb_pkg::RELOAD_W-1:0];
    end
  end

endmodule
